[sv/online_cosine_leader_clustering_top_defines.svh]
// Assertion macros for the online cosine leader clustering block
`ifndef ONLINE_COSINE_LEADER_CLUSTERING_TOP_DEFINES_SVH
`define ONLINE_COSINE_LEADER_CLUSTERING_TOP_DEFINES_SVH

// same-cycle implication, held off while reset is high
`define OCLC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oclc assertion failed");

// next-cycle implication, held off while reset is high
`define OCLC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oclc assertion failed");

`endif

[sv/oclc_pkg.sv]
// Shared types, constants and command/status bundles for the clustering block
package oclc_pkg;

   localparam int MAX_CLUSTERS_DEF   = 64;
   localparam int MAX_DIMENSIONS_DEF = 256;

   localparam int ELEM_W     = 16;
   localparam int DIM_W      = 9;
   localparam int THR_W      = 16;
   localparam int IDX_W      = 6;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [THR_W-1:0]     THR_RESET = 16'd26214;
   localparam logic [DIM_W-1:0]     DIM_RESET = 9'd256;
   localparam logic [CSR_IDX_W-1:0] CSR_JOIN_THRESHOLD    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSIONS_IN_USE = 4'd1;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         cluster_index;
      logic                     spawned;
      logic signed [ELEM_W-1:0] best_similarity;
      logic [COUNT_W-1:0]       member_total;
      logic                     store_full;
      logic                     skipped;
   } rsp_type;

   typedef struct packed {
      logic check;
      logic na_start;
      logic stream_start;
      logic nb_start;
      logic den_load;
      logic sim_div_start;
      logic compare;
      logic decide;
      logic spawn_start;
      logic count_read;
      logic upd_mul;
      logic upd_num;
      logic upd_div_start;
      logic upd_write;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic mismatch;
      logic no_clusters;
      logic stream_busy;
      logic sqrt_busy;
      logic div_busy;
      logic last_cluster;
      logic spawn_new;
      logic last_dim;
      logic out_free;
   } status_type;

endpackage

[sv/oclc_isqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle
module oclc_isqrt #(
   parameter int VW = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [VW-1:0]     value,
   output logic              busy,
   output logic              done,
   output logic [VW/2-1:0]   root
);
   logic [VW-1:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in, trial;
   logic          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = r_ff + bit_ff;
      if (start) begin
         v_in    = value;
         r_in    = '0;
         bit_in  = {2'b01, {(VW-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = r_ff[VW/2-1:0];
endmodule

[sv/oclc_div.sv]
// Restoring divider, one quotient bit per cycle, with overflow flag
module oclc_div #(
   parameter int W  = 58,
   parameter int QB = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [W-1:0]  num,
   input  logic [W-1:0]  den,
   output logic          busy,
   output logic          done,
   output logic [QB-1:0] quo,
   output logic          ovf
);
   localparam int CNTW = (QB > 1) ? $clog2(QB) : 1;

   logic [W-1:0]    rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QB-1:0]   q_ff, q_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in, ovf_ff, ovf_in, ge;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ge      = rem_ff >= dsh_ff;
      if (start) begin
         rem_in  = num;
         dsh_in  = den << (QB - 1);
         q_in    = '0;
         cnt_in  = CNTW'(QB - 1);
         ovf_in  = (num >> QB) >= den;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[QB-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = q_ff;
   assign ovf  = ovf_ff;
endmodule

[sv/oclc_dp.sv]
// Datapath: vector buffer, centroid and count memories, accumulators, result register
module oclc_dp #(
   parameter int MAX_CLUSTERS   = 64,
   parameter int MAX_DIMENSIONS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_beat,
   input  oclc_pkg::req_type                   req_data,
   input  logic                                csr_write,
   input  logic [oclc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [oclc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  oclc_pkg::cmd_type                   cmd,
   output oclc_pkg::status_type                status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output oclc_pkg::rsp_type                   rsp_data
);
   import oclc_pkg::*;

   localparam int DW   = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
   localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int CNTW = $clog2(MAX_DIMENSIONS + 2);
   localparam int TW   = $clog2(MAX_CLUSTERS + 1);
   localparam int CMPW = ((CNTW > DIM_W) ? CNTW : DIM_W) + 1;
   localparam int SW   = 31 + DW;
   localparam int SQW  = SW + (SW % 2);
   localparam int RW   = SQW / 2;
   localparam int DENW = 2 * RW;
   localparam int AW   = 32 + DW;
   localparam int QB   = 17;
   localparam int DVA  = AW + 18;
   localparam int DVB  = DENW + QB + 1;
   localparam int DVW0 = (DVA > DVB) ? DVA : DVB;
   localparam int DVW  = (DVW0 > 36) ? DVW0 : 36;
   localparam int CMD  = 1 << (CW + DW);

   // configuration
   logic [THR_W-1:0] thr_ff;
   logic [DIM_W-1:0] dim_ff;

   // memories
   logic signed [ELEM_W-1:0]  vb_mem [MAX_DIMENSIONS];
   logic signed [ELEM_W-1:0]  cm_mem [CMD];
   logic [COUNT_W-1:0]        mc_mem [MAX_CLUSTERS];
   logic signed [ELEM_W-1:0]  vb_q, cm_q;
   logic [COUNT_W-1:0]        mc_q;

   // load side
   logic [CNTW-1:0]   cnt_ff;
   logic [30:0]       sq_ff;
   logic              sqv_ff;
   logic [SW-1:0]     sx_ff;

   // stream / sweep
   logic              act_ff, mode_ff, v1_ff, m1_ff, v2_ff;
   logic [DW-1:0]     d_ff, d1_ff;
   logic [CW-1:0]     row_ff, best_ff;
   logic [TW-1:0]     total_ff;
   logic signed [31:0] xc_ff;
   logic [30:0]       cc_ff;
   logic signed [AW-1:0] dot_ff;
   logic [SW-1:0]     sc_ff;
   logic              stream_end;

   // norms, division, decision
   logic [RW-1:0]     na_ff, nb_ff, root;
   logic              sq_sel_ff, sq_start, sq_busy, sq_done;
   logic [DENW-1:0]   den_ff;
   logic [AW-1:0]     dot_mag;
   logic signed [32:0] prod_ff;
   logic signed [33:0] num_ff;
   logic [33:0]       num_mag;
   logic [COUNT_W:0]  n_plus;
   logic [DVW-1:0]    dv_num, dv_den;
   logic              dv_start, dv_busy, dv_done, dv_ovf, neg_ff;
   logic [QB-1:0]     dv_quo;
   logic signed [ELEM_W-1:0] res_ff, best_sim_ff;
   logic [THR_W-1:0]  thr_eff;
   logic              want_spawn, room;
   logic              skip_ff, spawn_ff, full_ff;
   logic [COUNT_W-1:0] new_count;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   function automatic logic signed [ELEM_W-1:0] clamp_q15(input logic neg, input logic ovf,
                                                         input logic [QB-1:0] q);
      logic signed [ELEM_W-1:0] r;
      if (neg) begin
         r = (ovf || q[QB-1] || (q[ELEM_W-1] && (q[ELEM_W-2:0] != '0))) ? 16'sh8000 :
             -$signed(q[ELEM_W-1:0]);
      end else begin
         r = (ovf || q[QB-1] || q[ELEM_W-1]) ? 16'sh7fff : $signed(q[ELEM_W-1:0]);
      end
      return r;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         dim_ff <= DIM_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_JOIN_THRESHOLD) begin
            thr_ff <= csr_data;
         end else if (csr_index == CSR_DIMENSIONS_IN_USE) begin
            dim_ff <= csr_data[DIM_W-1:0];
         end
      end
   end

   // element load and squared-norm accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sqv_ff <= 1'b0;
         sx_ff  <= '0;
      end else begin
         sqv_ff <= in_beat && (cnt_ff < CNTW'(MAX_DIMENSIONS));
         if (cmd.finish) begin
            cnt_ff <= '0;
         end else if (in_beat && (cnt_ff <= CNTW'(MAX_DIMENSIONS))) begin
            cnt_ff <= cnt_ff + CNTW'(1);
         end
         if (cmd.finish) begin
            sx_ff  <= '0;
         end else if (sqv_ff) begin
            sx_ff <= sx_ff + SW'(sq_ff);
         end
      end
      sq_ff <= 31'(req_data.element * req_data.element);
   end

   always_ff @(posedge clock) begin
      if (in_beat && (cnt_ff < CNTW'(MAX_DIMENSIONS))) begin
         vb_mem[cnt_ff[DW-1:0]] <= req_data.element;
      end
      vb_q <= vb_mem[d_ff];
   end

   // centroid memory: spawn sweep and mean update write, one registered read
   always_ff @(posedge clock) begin
      if (v1_ff && m1_ff) begin
         cm_mem[{row_ff, d1_ff}] <=
            (CMPW'(d1_ff) < CMPW'(dim_ff)) ? vb_q : '0;
      end else if (cmd.upd_write) begin
         cm_mem[{row_ff, d_ff}] <= res_ff;
      end
      cm_q <= cm_mem[{row_ff, d_ff}];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && !skip_ff) begin
         mc_mem[row_ff] <= new_count;
      end
      if (cmd.count_read) begin
         mc_q <= mc_mem[row_ff];
      end
   end

   assign stream_end = mode_ff ? (d_ff == DW'(MAX_DIMENSIONS - 1)) : status.last_dim;

   // row stream: issue, read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         v1_ff <= act_ff;
         v2_ff <= v1_ff && !m1_ff;
         if (cmd.stream_start || cmd.spawn_start) begin
            act_ff <= 1'b1;
         end else if (act_ff && stream_end) begin
            act_ff <= 1'b0;
         end
      end
      m1_ff <= mode_ff;
      d1_ff <= d_ff;
      if (cmd.stream_start || cmd.spawn_start || cmd.count_read) begin
         d_ff <= '0;
      end else if ((act_ff && !stream_end) || (cmd.upd_write && !status.last_dim)) begin
         d_ff <= d_ff + DW'(1);
      end
      if (cmd.stream_start) begin
         mode_ff <= 1'b0;
      end else if (cmd.spawn_start) begin
         mode_ff <= 1'b1;
      end
      xc_ff <= vb_q * cm_q;
      cc_ff <= 31'(cm_q * cm_q);
      if (cmd.stream_start) begin
         dot_ff <= '0;
         sc_ff  <= '0;
      end else if (v2_ff) begin
         dot_ff <= dot_ff + AW'(xc_ff);
         sc_ff  <= sc_ff + SW'(cc_ff);
      end
   end

   // norms
   assign sq_start = cmd.na_start || cmd.nb_start;

   oclc_isqrt #(.VW(SQW)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (cmd.na_start ? SQW'(sx_ff) : SQW'(sc_ff)),
      .busy  (sq_busy),
      .done  (sq_done),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (sq_start) begin
         sq_sel_ff <= cmd.nb_start;
      end
      if (sq_done && !sq_sel_ff) begin
         na_ff <= root;
      end
      if (sq_done && sq_sel_ff) begin
         nb_ff <= root;
      end
      if (cmd.den_load) begin
         den_ff <= na_ff * nb_ff;
      end
   end

   // shared rounding divider: similarity or running mean
   assign dot_mag = dot_ff[AW-1] ? AW'(-dot_ff) : AW'(dot_ff);
   assign num_mag = num_ff[33] ? 34'(-num_ff) : 34'(num_ff);
   assign n_plus  = {1'b0, mc_q} + (COUNT_W+1)'(1);

   always_comb begin
      if (cmd.upd_div_start) begin
         dv_num = (DVW'(num_mag) << 1) + DVW'(n_plus);
         dv_den = DVW'(n_plus) << 1;
      end else begin
         dv_num = (DVW'(dot_mag) << 16) + DVW'(den_ff);
         dv_den = DVW'(den_ff) << 1;
      end
   end

   assign dv_start = cmd.upd_div_start || (cmd.sim_div_start && (den_ff != '0));

   oclc_div #(.W(DVW), .QB(QB)) u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .busy  (dv_busy),
      .done  (dv_done),
      .quo   (dv_quo),
      .ovf   (dv_ovf)
   );

   always_ff @(posedge clock) begin
      if (cmd.upd_mul) begin
         prod_ff <= cm_q * $signed({1'b0, mc_q});
      end
      if (cmd.upd_num) begin
         num_ff <= 34'(prod_ff) + 34'(vb_q);
      end
      if (cmd.upd_div_start) begin
         neg_ff <= num_ff[33];
      end else if (cmd.sim_div_start) begin
         neg_ff <= dot_ff[AW-1];
      end
      if (cmd.sim_div_start && (den_ff == '0)) begin
         res_ff <= '0;
      end else if (dv_done) begin
         res_ff <= clamp_q15(neg_ff, dv_ovf, dv_quo);
      end
   end

   // decision
   assign thr_eff    = (thr_ff > 16'd32768) ? 16'd32768 : thr_ff;
   assign room       = total_ff < TW'(MAX_CLUSTERS);
   assign want_spawn = (total_ff == '0) ||
                       ($signed({best_sim_ff[ELEM_W-1], best_sim_ff}) < $signed({1'b0, thr_eff}));
   assign new_count  = spawn_ff ? COUNT_W'(1) :
                       ((mc_q == '1) ? mc_q : mc_q + COUNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.finish && !skip_ff && spawn_ff) begin
         total_ff <= total_ff + TW'(1);
      end
      if (cmd.check) begin
         skip_ff     <= status.mismatch;
         spawn_ff    <= 1'b0;
         full_ff     <= 1'b0;
         best_sim_ff <= status.no_clusters ? 16'sh0000 : 16'sh8000;
         best_ff     <= '0;
         row_ff      <= '0;
      end else if (cmd.compare) begin
         if (res_ff > best_sim_ff) begin
            best_sim_ff <= res_ff;
            best_ff     <= row_ff;
         end
         row_ff <= row_ff + CW'(1);
      end else if (cmd.decide) begin
         spawn_ff <= want_spawn && room;
         full_ff  <= want_spawn && !room;
         row_ff   <= (want_spawn && room) ? CW'(total_ff) : best_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         if (skip_ff) begin
            rsp_data_ff <= '{cluster_index: '0, spawned: 1'b0, best_similarity: '0,
                             member_total: '0, store_full: 1'b0, skipped: 1'b1};
         end else begin
            rsp_data_ff.cluster_index   <= IDX_W'(row_ff);
            rsp_data_ff.spawned         <= spawn_ff;
            rsp_data_ff.best_similarity <= best_sim_ff;
            rsp_data_ff.member_total    <= new_count;
            rsp_data_ff.store_full      <= full_ff;
            rsp_data_ff.skipped         <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status.mismatch     = (dim_ff == '0) || (CMPW'(dim_ff) > CMPW'(MAX_DIMENSIONS)) ||
                            (CMPW'(cnt_ff) != CMPW'(dim_ff));
      status.no_clusters  = total_ff == '0;
      status.stream_busy  = act_ff || v1_ff || v2_ff;
      status.sqrt_busy    = sq_busy;
      status.div_busy     = dv_busy;
      status.last_cluster = (TW'(row_ff) + TW'(1)) == total_ff;
      status.spawn_new    = want_spawn && room;
      status.last_dim     = (CMPW'(d_ff) + CMPW'(1)) == CMPW'(dim_ff);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end
endmodule

[sv/oclc_ctrl.sv]
// Controller: sequences load, centroid scan, spawn sweep and mean update
module oclc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  oclc_pkg::status_type status,
   output oclc_pkg::cmd_type    cmd
);
   import oclc_pkg::*;

   typedef enum logic [4:0] {
      IDLE, CHECK, NA_GO, NA_WAIT, CL_GO, CL_WAIT, NB_GO, NB_WAIT, CL_MUL,
      SIM_GO, SIM_WAIT, CL_CMP, DECIDE, SP_GO, SP_WAIT, CNT_RD, UP_RD,
      UP_DATA, UP_NUM, UP_GO, UP_WAIT, UP_WR, FIN
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && req_last) state_in = CHECK;
         end
         CHECK: begin
            cmd.check = 1'b1;
            if (status.mismatch) state_in = FIN;
            else if (status.no_clusters) state_in = DECIDE;
            else state_in = NA_GO;
         end
         NA_GO: begin
            cmd.na_start = 1'b1;
            state_in     = NA_WAIT;
         end
         NA_WAIT: begin
            if (!status.sqrt_busy) state_in = CL_GO;
         end
         CL_GO: begin
            cmd.stream_start = 1'b1;
            state_in         = CL_WAIT;
         end
         CL_WAIT: begin
            if (!status.stream_busy) state_in = NB_GO;
         end
         NB_GO: begin
            cmd.nb_start = 1'b1;
            state_in     = NB_WAIT;
         end
         NB_WAIT: begin
            if (!status.sqrt_busy) state_in = CL_MUL;
         end
         CL_MUL: begin
            cmd.den_load = 1'b1;
            state_in     = SIM_GO;
         end
         SIM_GO: begin
            cmd.sim_div_start = 1'b1;
            state_in          = SIM_WAIT;
         end
         SIM_WAIT: begin
            if (!status.div_busy) state_in = CL_CMP;
         end
         CL_CMP: begin
            cmd.compare = 1'b1;
            state_in    = status.last_cluster ? DECIDE : CL_GO;
         end
         DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.spawn_new ? SP_GO : CNT_RD;
         end
         SP_GO: begin
            cmd.spawn_start = 1'b1;
            state_in        = SP_WAIT;
         end
         SP_WAIT: begin
            if (!status.stream_busy) state_in = FIN;
         end
         CNT_RD: begin
            cmd.count_read = 1'b1;
            state_in       = UP_RD;
         end
         UP_RD: begin
            state_in = UP_DATA;
         end
         UP_DATA: begin
            cmd.upd_mul = 1'b1;
            state_in    = UP_NUM;
         end
         UP_NUM: begin
            cmd.upd_num = 1'b1;
            state_in    = UP_GO;
         end
         UP_GO: begin
            cmd.upd_div_start = 1'b1;
            state_in          = UP_WAIT;
         end
         UP_WAIT: begin
            if (!status.div_busy) state_in = UP_WR;
         end
         UP_WR: begin
            cmd.upd_write = 1'b1;
            state_in      = status.last_dim ? FIN : UP_RD;
         end
         FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end
endmodule

[sv/online_cosine_leader_clustering_top.sv]
// Online cosine leader clustering: elements stream in one beat each; the beat
// flagged last_element triggers a scan of all K stored centroids and one result
// beat. Element beats are taken only while the controller is idle. After the
// last beat the block scans the centroids (per centroid: the row stream through
// the centroid memory read port, a 2-bit-per-cycle square root and a 17-step
// restoring divider), then either writes a new centroid row of MAX_DIMENSIONS
// elements, or updates the first dimensions_in_use elements of the joined
// centroid, one element at a time through the same divider. A wrong-length
// vector skips the scan and goes straight to its result. The result sits in an output
// register, so the next vector's elements are taken while it waits. No clearing
// pass is needed after reset.
`include "online_cosine_leader_clustering_top_defines.svh"

module online_cosine_leader_clustering_top #(
   parameter int MAX_CLUSTERS   = oclc_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_DIMENSIONS = oclc_pkg::MAX_DIMENSIONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  oclc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output oclc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [oclc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [oclc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import oclc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       in_beat;
   logic       skip_clean, spawn_clean, units_idle;

   assign csr_ready = 1'b1;
   assign in_beat   = req_valid && req_ready;

   oclc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_element),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   oclc_dp #(
      .MAX_CLUSTERS   (MAX_CLUSTERS),
      .MAX_DIMENSIONS (MAX_DIMENSIONS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (in_beat),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign skip_clean  = !rsp_data.spawned && !rsp_data.store_full &&
                        (rsp_data.member_total == '0);
   assign spawn_clean = (rsp_data.member_total == 16'd1) && !rsp_data.store_full;
   assign units_idle  = !status.stream_busy && !status.sqrt_busy && !status.div_busy;

   // a skipped vector carries no other information
   `OCLC_ASSERT_IMPL(a_skip_clean, clock, reset, rsp_valid && rsp_data.skipped, skip_clean)
   // a fresh cluster starts with one member and never reports a full store
   `OCLC_ASSERT_IMPL(a_spawn_one, clock, reset, rsp_valid && rsp_data.spawned, spawn_clean)
   // taking elements only while every arithmetic unit is idle
   `OCLC_ASSERT_IMPL(a_idle_units, clock, reset, req_ready, units_idle)
   // the last beat of a vector stops intake for the scan
   `OCLC_ASSERT_NEXT(a_last_stalls, clock, reset, in_beat && req_data.last_element, !req_ready)
endmodule

[sim/cluster_checker.sv]
// Checker for the clustering block: watches all channels, predicts results and compares them
`timescale 1ns / 1ps

module cluster_checker
   import oclc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   localparam int NCLUST = MAX_CLUSTERS_DEF;
   localparam int NDIM   = MAX_DIMENSIONS_DEF;
   localparam int COUNT_CAP = 65535;
   localparam int ONE_Q15   = 32768;

   logic signed [ELEM_W-1:0] centroid [NCLUST][NDIM];
   logic [COUNT_W-1:0]       members [NCLUST];
   logic signed [ELEM_W-1:0] vec_buf [NDIM];
   int                       clusters_live;
   int                       elem_seen;
   logic [THR_W-1:0]         thr_reg;
   logic [DIM_W-1:0]         dim_reg;
   rsp_type                  expected_results [$];
   int                       mismatches;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // round to nearest, halves away from zero; den > 0
   function automatic longint round_div(input longint num, input longint den);
      longint m, q;
      m = (num < 0) ? -num : num;
      q = (2 * m + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic int cosine_q15(input int row, input int dim);
      longint          dot, x, c, s;
      longint unsigned sx, sc, na, nb;
      dot = 0;
      sx  = 0;
      sc  = 0;
      for (int d = 0; d < dim; d++) begin
         x = vec_buf[d];
         c = centroid[row][d];
         dot += x * c;
         sx  += x * x;
         sc  += c * c;
      end
      na = int_sqrt(sx);
      nb = int_sqrt(sc);
      if (na == 0 || nb == 0) return 0;
      s = round_div(dot * ONE_Q15, longint'(na * nb));
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return int'(s);
   endfunction

   // queue one expected result at the tail
   task automatic add_expected(input rsp_type r);
      expected_results.insert(expected_results.size(), r);
   endtask

   task automatic predict_vector();
      rsp_type exp_rsp;
      int      count, dim, best, best_sim, sim, thr, n, total;
      bit      want_spawn;
      longint  num;
      count = elem_seen;
      dim = dim_reg;
      elem_seen = 0;
      exp_rsp = '0;
      if (dim == 0 || dim > NDIM || count != dim) begin
         exp_rsp.skipped = 1'b1;
         add_expected(exp_rsp);
         return;
      end
      best = 0;
      best_sim = -ONE_Q15;
      for (int c = 0; c < clusters_live; c++) begin
         sim = cosine_q15(c, dim);
         if (sim > best_sim) begin
            best_sim = sim;
            best = c;
         end
      end
      if (clusters_live == 0) best_sim = 0;
      thr = (thr_reg > ONE_Q15) ? ONE_Q15 : int'(thr_reg);
      want_spawn = (clusters_live == 0) || (best_sim < thr);
      if (want_spawn && clusters_live < NCLUST) begin
         best = clusters_live;
         for (int d = 0; d < NDIM; d++) centroid[best][d] = (d < dim) ? vec_buf[d] : '0;
         members[best] = 1;
         clusters_live++;
         total = 1;
         exp_rsp.spawned = 1'b1;
      end else begin
         n = members[best];
         for (int d = 0; d < dim; d++) begin
            num = longint'(centroid[best][d]) * n + longint'(vec_buf[d]);
            centroid[best][d] = ELEM_W'(round_div(num, longint'(n) + 1));
         end
         total = (n < COUNT_CAP) ? n + 1 : COUNT_CAP;
         members[best] = COUNT_W'(total);
         if (want_spawn) exp_rsp.store_full = 1'b1;
      end
      exp_rsp.cluster_index   = IDX_W'(best);
      exp_rsp.best_similarity = ELEM_W'(best_sim);
      exp_rsp.member_total    = COUNT_W'(total);
      add_expected(exp_rsp);
   endtask

   task automatic report(input string what, input rsp_type e, input rsp_type a);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t mismatch (%s): exp idx=%0d sp=%0b sim=%0d tot=%0d full=%0b skip=%0b",
                  $time, what, e.cluster_index, e.spawned, e.best_similarity, e.member_total,
                  e.store_full, e.skipped);
         $display("   act idx=%0d sp=%0b sim=%0d tot=%0d full=%0b skip=%0b",
                  a.cluster_index, a.spawned, a.best_similarity, a.member_total,
                  a.store_full, a.skipped);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clusters_live = 0;
         elem_seen = 0;
         thr_reg = THR_RESET;
         dim_reg = DIM_RESET;
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report("no result expected", '0, rsp_data);
            end else begin
               rsp_type e;
               e = expected_results.pop_front();
               if (e.cluster_index !== rsp_data.cluster_index ||
                   e.spawned !== rsp_data.spawned ||
                   e.best_similarity !== rsp_data.best_similarity ||
                   e.member_total !== rsp_data.member_total ||
                   e.store_full !== rsp_data.store_full ||
                   e.skipped !== rsp_data.skipped)
                  report("field", e, rsp_data);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_JOIN_THRESHOLD) thr_reg = csr_data[THR_W-1:0];
            else if (csr_index == CSR_DIMENSIONS_IN_USE) dim_reg = csr_data[DIM_W-1:0];
         end
         if (req_valid && req_ready) begin
            if (elem_seen < NDIM) vec_buf[elem_seen] = req_data.element;
            if (elem_seen <= NDIM) elem_seen = elem_seen + 1;
            if (req_data.last_element) predict_vector();
         end
      end
   end

   assign fail_count = mismatches;
   assign pending    = expected_results.size();

endmodule

[sim/testbench.sv]
// Testbench top: clock, reset, stimulus and verdict for the clustering block
`timescale 1ns / 1ps

module testbench;
   import oclc_pkg::*;

   localparam int TARGET_BEATS = 1350;
   localparam int SETTLE_CYCLES = 64;

   logic                  clock;
   logic                  reset;
   logic                  req_valid, req_ready;
   req_type               req_data;
   logic                  rsp_valid, rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count, pending;

   int  beats_sent, vectors_sent, settings_used;
   bit  send_quiet, recv_quiet;
   int  cur_dim;
   logic signed [ELEM_W-1:0] proto [4][256];

   online_cosine_leader_clustering_top dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   cluster_checker checker_inst (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #200ms;
      $display("simulation failed");
      $finish;
   end

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver stalls, with quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_quiet <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) recv_quiet <= ~recv_quiet;
         rsp_ready <= recv_quiet ? 1'b1 : (pick_gap(1'b0) == 0);
      end
   end

   task automatic send_beat(input logic signed [ELEM_W-1:0] elem, input bit last);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{element: elem, last_element: last};
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      gap = pick_gap(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold until every result is in and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
      if (idx == CSR_DIMENSIONS_IN_USE) cur_dim = value & 9'h1FF;
   endtask

   // style: 0 near prototype, 1 random, 2 all max, 3 all min, 4 zeros
   task automatic send_vector(input int len, input int style);
      int p, v;
      logic signed [ELEM_W-1:0] e;
      p = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         case (style)
            0: begin
               v = int'(proto[p][i % 256]) + int'($urandom_range(0, 4000)) - 2000;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               e = ELEM_W'(v);
            end
            1: e = ELEM_W'($urandom);
            2: e = 16'sh7FFF;
            3: e = 16'sh8000;
            default: e = '0;
         endcase
         send_beat(e, i == len - 1);
      end
      vectors_sent++;
   endtask

   task automatic new_prototypes();
      for (int p = 0; p < 4; p++)
         for (int d = 0; d < 256; d++) proto[p][d] = ELEM_W'($urandom);
   endtask

   task automatic random_vector();
      int r, len;
      r = $urandom_range(0, 99);
      len = cur_dim;
      if (r >= 85) begin
         // wrong length: one off, or past the buffer now and then
         if ($urandom_range(0, 9) == 0) len = 257 + $urandom_range(0, 3);
         else if (cur_dim > 1 && $urandom_range(0, 1)) len = cur_dim - 1;
         else len = cur_dim + 1;
         send_vector(len, 1);
      end else if (r >= 75) send_vector(len, $urandom_range(2, 4));
      else if (r >= 60) send_vector(len, 1);
      else send_vector(len, 0);
   endtask

   function automatic int pick_threshold();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return 32768;
         2: return 65535;
         3: return 26214;
         4: return $urandom_range(0, 65535);
         default: return $urandom_range(20000, 32000);
      endcase
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 1;
      if (r < 90) return $urandom_range(2, 8);
      return $urandom_range(9, 32);
   endfunction

   initial begin
      int nvec;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      beats_sent = 0;
      vectors_sent = 0;
      settings_used = 0;
      send_quiet = 1'b0;
      cur_dim = DIM_RESET;
      new_prototypes();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, join, zero norm, wrong lengths, invalid dimensions
      csr_write(CSR_DIMENSIONS_IN_USE, 4);
      send_vector(4, 2);
      send_vector(4, 2);
      send_vector(4, 3);
      send_vector(4, 4);
      send_vector(3, 1);
      send_vector(5, 1);
      csr_write(CSR_JOIN_THRESHOLD, 0);
      send_vector(4, 3);
      csr_write(CSR_DIMENSIONS_IN_USE, 0);
      send_vector(1, 1);
      csr_write(CSR_DIMENSIONS_IN_USE, 300);
      send_vector(2, 1);

      // full dimension, a couple of vectors only
      csr_write(CSR_DIMENSIONS_IN_USE, 256);
      csr_write(CSR_JOIN_THRESHOLD, 26214);
      send_vector(256, 0);
      send_vector(256, 0);

      // fill the store at the smallest dimension
      csr_write(CSR_DIMENSIONS_IN_USE, 1);
      csr_write(CSR_JOIN_THRESHOLD, 32768);
      repeat (70) send_vector(1, 1);

      while (beats_sent < TARGET_BEATS) begin
         csr_write(CSR_DIMENSIONS_IN_USE, pick_dim());
         csr_write(CSR_JOIN_THRESHOLD, pick_threshold());
         new_prototypes();
         send_quiet = ($urandom_range(0, 3) == 0);
         nvec = $urandom_range(8, 20);
         repeat (nvec) random_vector();
      end

      settle();
      $display("covered %0d element beats in %0d vectors over %0d register writes",
               beats_sent, vectors_sent, settings_used);
      $display("store filled to capacity, joins, spawns, skips and extreme thresholds exercised");
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/oclc_pkg.sv
sv/oclc_isqrt.sv
sv/oclc_div.sv
sv/oclc_dp.sv
sv/oclc_ctrl.sv
sv/online_cosine_leader_clustering_top.sv
sim/cluster_checker.sv
sim/testbench.sv
